>>> design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, idle during reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication in the next cycle, idle during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// implication in the next cycle, also checked across reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/swmin_pkg.sv
// types and constants of the sliding window minimum unit
`timescale 1ns / 1ps

package swmin_pkg;

  localparam int DATA_W = 32;
  localparam int CFG_W  = 11;

  typedef logic signed [DATA_W-1:0] sample_t;

  // what every cell of the chain does in a cycle
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_GROW,
    OP_SLIDE,
    OP_DROP
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     first;
    sample_t  sample;
  } cell_cmd_t;

  function automatic sample_t smin(input sample_t a, input sample_t b);
    smin = (a > b) ? b : a;
  endfunction

endpackage

>>> design/swmin_cell.sv
// one cell of the running-minimum chain
`timescale 1ns / 1ps

module swmin_cell
  import swmin_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_cmd_t cmd,
  input  logic      prev_live,
  input  logic      next_live,
  input  sample_t   next_value,
  output logic      live,
  output sample_t   value,
  output sample_t   value_next
);

  logic live_q;
  logic live_next;

  // a first-of-sequence beat empties the chain before the sample goes in
  assign live = live_q & ~cmd.first;

  always_comb begin
    value_next = value;
    live_next  = live_q;
    unique case (cmd.op)
      OP_GROW: begin
        if (live) begin
          value_next = smin(value, cmd.sample);
          live_next  = 1'b1;
        end else if (prev_live) begin
          value_next = cmd.sample;
          live_next  = 1'b1;
        end else begin
          live_next  = 1'b0;
        end
      end
      OP_SLIDE: begin
        // window full: everything moves one cell toward the head
        value_next = next_live ? smin(next_value, cmd.sample) : cmd.sample;
        live_next  = live;
      end
      OP_DROP: begin
        value_next = next_value;
        live_next  = next_live;
      end
      default: begin
        value_next = value;
        live_next  = live_q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live_q <= 1'b0;
    end else begin
      live_q <= live_next;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

>>> design/sliding_window_minimum_unit.sv
// sliding window minimum over a stream of signed samples
//
// input beats carry a signed sample in s_tdata and a first-of-sequence flag in
// s_tuser; output beats carry the minimum of the last window_size samples in
// m_tdata. no beat comes out until window_size samples of the current sequence
// have gone in. the user is to write window_size through cfg_wen / cfg_wdata
// only while the unit is idle; the unit does not enforce this. 0 acts as 1,
// values above WINDOW_MAX as WINDOW_MAX. a result is buffered the cycle after
// its sample is accepted, and one sample is taken per clock while s_tready is
// high. cell j of the chain holds the minimum of the samples that the window
// still covers after j more slides; the head cell is the window minimum, so
// each beat costs one compare per cell. lowering window_size during a sequence
// makes the chain drop one old entry per cycle with s_tready low, until no entry
// is held beyond the new size. a two-beat output buffer lets the input go on
// while a result waits; once it holds two results s_tready drops until m_tready
// takes one. reset empties the chain and the buffer and sets window_size to 1.
`timescale 1ns / 1ps

module sliding_window_minimum_unit
  import swmin_pkg::*;
#(
  parameter int WINDOW_MAX = 1024
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wen,
  input  logic [CFG_W-1:0]        cfg_wdata,   // window_size
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic signed [DATA_W-1:0] s_tdata,    // sample
  input  logic                    s_tuser,     // first_of_sequence
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic signed [DATA_W-1:0] m_tdata     // window_min
);

  localparam int KW = $clog2(WINDOW_MAX + 1);
  localparam int WW = (KW > CFG_W) ? KW : CFG_W;

  logic [CFG_W-1:0] window_size;
  logic [WW-1:0]    win_eff;
  logic [KW-1:0]    live_len;
  logic [KW-1:0]    live_len_next;
  logic [KW-1:0]    fill;
  logic [KW-1:0]    fill_next;
  logic             shrink;
  logic             accept;
  logic             push;
  logic             pop;
  cell_cmd_t        cmd;

  logic    live_w  [WINDOW_MAX];
  sample_t value_w [WINDOW_MAX];
  sample_t vnext_w [WINDOW_MAX];

  logic [1:0] obuf_cnt;
  logic       obuf_slot;
  sample_t    obuf0;
  sample_t    obuf1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= CFG_W'(1);
    end else if (cfg_wen) begin
      window_size <= cfg_wdata;
    end
  end

  always_comb begin
    if (window_size == '0) begin
      win_eff = WW'(1);
    end else if (WW'(window_size) > WW'(WINDOW_MAX)) begin
      win_eff = WW'(WINDOW_MAX);
    end else begin
      win_eff = WW'(window_size);
    end
  end

  assign shrink   = WW'(live_len) > win_eff;
  assign s_tready = !shrink && (obuf_cnt != 2'd2);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cmd.sample    = s_tdata;
    cmd.first     = accept && s_tuser;
    cmd.op        = OP_HOLD;
    live_len_next = live_len;
    fill_next     = fill;
    if (shrink) begin
      cmd.op        = OP_DROP;
      live_len_next = live_len - KW'(1);
    end else if (accept) begin
      if (s_tuser || (WW'(live_len) < win_eff)) begin
        cmd.op        = OP_GROW;
        live_len_next = (s_tuser ? '0 : live_len) + KW'(1);
      end else begin
        cmd.op        = OP_SLIDE;
      end
      if (s_tuser) begin
        fill_next = KW'(1);
      end else if (fill != KW'(WINDOW_MAX)) begin
        fill_next = fill + KW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live_len <= '0;
      fill     <= '0;
    end else begin
      live_len <= live_len_next;
      fill     <= fill_next;
    end
  end

  for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
    logic    prev_l;
    logic    next_l;
    sample_t next_v;

    if (j == 0) begin : g_head
      assign prev_l = 1'b1;
    end else begin : g_mid
      assign prev_l = live_w[j-1];
    end

    if (j == WINDOW_MAX - 1) begin : g_tail
      assign next_l = 1'b0;
      assign next_v = '0;
    end else begin : g_body
      assign next_l = live_w[j+1];
      assign next_v = value_w[j+1];
    end

    swmin_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .prev_live  (prev_l),
      .next_live  (next_l),
      .next_value (next_v),
      .live       (live_w[j]),
      .value      (value_w[j]),
      .value_next (vnext_w[j])
    );
  end

  // two-entry output buffer
  assign push      = accept && (WW'(fill_next) >= win_eff);
  assign pop       = m_tvalid && m_tready;
  assign obuf_slot = (obuf_cnt == 2'd2) || ((obuf_cnt == 2'd1) && !pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      obuf_cnt <= '0;
    end else begin
      obuf_cnt <= obuf_cnt + 2'(push) - 2'(pop);
    end
  end

  // a new beat lands in the head slot when the buffer is empty or drains now
  always_ff @(posedge clk) begin
    if (push && !obuf_slot) begin
      obuf0 <= vnext_w[0];
    end else if (pop) begin
      obuf0 <= obuf1;
    end
    if (push && obuf_slot) begin
      obuf1 <= vnext_w[0];
    end
  end

  assign m_tvalid = (obuf_cnt != '0);
  assign m_tdata  = obuf0;

endmodule

>>> design/swmin_checker.sv
// port-level checks of the sliding window minimum unit
`timescale 1ns / 1ps
`include "assert_macros.svh"

module swmin_checker
  import swmin_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     s_tvalid,
  input logic                     s_tready,
  input logic                     m_tvalid,
  input logic                     m_tready,
  input logic signed [DATA_W-1:0] m_tdata
);

  // a stalled result stays offered
  `ASSERT_NEXT(a_hold_valid, clk, rst, m_tvalid && !m_tready, m_tvalid)
  // and does not change under the receiver
  `ASSERT_NEXT(a_hold_data, clk, rst, m_tvalid && !m_tready, $stable(m_tdata))
  // a result only follows an accepted sample
  `ASSERT_SAME(a_cause, clk, rst, $rose(m_tvalid), $past(s_tvalid && s_tready))
  // reset empties the output buffer
  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !m_tvalid)

endmodule

bind sliding_window_minimum_unit swmin_checker u_swmin_checker (.*);
